// ----- rtl/vmsp_pkg.sv -----
`timescale 1ns / 1ps
package vmsp_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [APB_ADDR_W-3:0] REG_ENABLED = '0;

    localparam logic [1:0] KIND_PUSH_VIDEO = 2'd0;
    localparam logic [1:0] KIND_PUSH_MD    = 2'd1;
    localparam logic [1:0] KIND_PULL       = 2'd2;
    localparam logic [1:0] KIND_FLUSH      = 2'd3;

    localparam logic [1:0] RK_VIDEO = 2'd0;
    localparam logic [1:0] RK_MD    = 2'd1;
    localparam logic [1:0] RK_PAIR  = 2'd2;
    localparam logic [1:0] RK_NONE  = 2'd3;

    typedef struct packed {
        logic [7:0]  idx;
        logic [31:0] seq;
    } t_desc;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  buffer_index;
        logic [31:0] sequence_req;
    } t_item;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [7:0]  video_index;
        logic [7:0]  md_index;
        logic [31:0] pair_sequence;
    } t_rec;

    typedef struct packed {
        logic       clear;
        logic       push;
        logic [1:0] pop;
    } t_qop;

endpackage

// ----- rtl/vmsp_in_if.sv -----
`timescale 1ns / 1ps
interface vmsp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  buffer_index;
    logic [31:0] sequence_req;

    modport source (output valid, kind, buffer_index, sequence_req, input ready);
    modport sink   (input valid, kind, buffer_index, sequence_req, output ready);
endinterface

// ----- rtl/vmsp_out_if.sv -----
`timescale 1ns / 1ps
interface vmsp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  video_index;
    logic [7:0]  md_index;
    logic [31:0] pair_sequence;
    logic        last;

    modport source (
        output valid, result_kind, video_index, md_index, pair_sequence, last,
        input  ready
    );
    modport sink (
        input  valid, result_kind, video_index, md_index, pair_sequence, last,
        output ready
    );
endinterface

// ----- rtl/vmsp_queue.sv -----
`timescale 1ns / 1ps
module vmsp_queue
    import vmsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qop          i_op,
    input  t_desc         i_push_desc,
    output t_desc         o_front0,
    output t_desc         o_front1,
    output logic [CW-1:0] o_count
);

    t_desc         r_ent [QUEUE_DEPTH];
    t_desc         n_ent [QUEUE_DEPTH];
    t_desc         ext   [QUEUE_DEPTH+2];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic [CW-1:0] mid;
    logic          push_ok;

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
            ext[i] = '0;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ext[i] = r_ent[i];
        end
        mid     = r_cnt - CW'(i_op.pop);
        push_ok = i_op.push && (mid < CW'(QUEUE_DEPTH));
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            unique case (i_op.pop)
                2'd1:    n_ent[i] = ext[i+1];
                2'd2:    n_ent[i] = ext[i+2];
                default: n_ent[i] = ext[i];
            endcase
            if (push_ok && (mid == CW'(i))) begin
                n_ent[i] = i_push_desc;
            end
        end
        if (i_op.clear) begin
            n_cnt = '0;
        end else begin
            n_cnt = mid + CW'(push_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_front0 = r_ent[0];
    assign o_front1 = r_ent[1];
    assign o_count  = r_cnt;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_DEPTH))
        else $error("queue count over depth");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op.clear |=> r_cnt == '0)
        else $error("queue not empty after clear");

    a_pop_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_op.clear |-> CW'(i_op.pop) <= r_cnt)
        else $error("pop beyond queue fill");

endmodule

// ----- rtl/vmsp_decide.sv -----
`timescale 1ns / 1ps
module vmsp_decide
    import vmsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_go,
    input  t_item         i_item,
    input  logic          i_enabled,
    input  t_desc         i_v0,
    input  t_desc         i_v1,
    input  logic [CW-1:0] i_vcnt,
    input  t_desc         i_m0,
    input  t_desc         i_m1,
    input  logic [CW-1:0] i_mcnt,
    output t_qop          o_vop,
    output t_qop          o_mop,
    output t_rec          o_res0,
    output t_rec          o_res1,
    output logic [1:0]    o_num
);

    t_qop       vop;
    t_qop       mop;
    logic [1:0] num;
    logic       v_full;
    logic       m_full;

    assign v_full = (i_vcnt == CW'(QUEUE_DEPTH));
    assign m_full = (i_mcnt == CW'(QUEUE_DEPTH));

    always_comb begin
        vop    = '0;
        mop    = '0;
        num    = 2'd0;
        o_res0 = '{result_kind: RK_NONE, default: '0};
        o_res1 = '{result_kind: RK_NONE, default: '0};
        unique case (i_item.kind)
            KIND_FLUSH: begin
                vop.clear = 1'b1;
                mop.clear = 1'b1;
            end
            KIND_PUSH_VIDEO: begin
                if (i_enabled) begin
                    vop.push = 1'b1;
                    if (v_full) begin
                        vop.pop = 2'd1;
                        num     = 2'd1;
                        o_res0  = '{RK_VIDEO, i_v0.idx, 8'd0, i_v0.seq};
                    end
                end
            end
            KIND_PUSH_MD: begin
                if (i_enabled) begin
                    mop.push = 1'b1;
                    if (((i_mcnt != '0) && (i_m0.seq == i_item.sequence_req)) || m_full) begin
                        mop.pop = 2'd1;
                        num     = 2'd1;
                        o_res0  = '{RK_MD, 8'd0, i_m0.idx, i_m0.seq};
                    end
                end
            end
            default: begin
                num = 2'd1;
                if (i_enabled && (i_vcnt != '0) && (i_mcnt != '0)) begin
                    priority if (i_v0.seq == i_m0.seq) begin
                        vop.pop = 2'd1;
                        mop.pop = 2'd1;
                        o_res0  = '{RK_PAIR, i_v0.idx, i_m0.idx, i_v0.seq};
                    end else if ((i_v0.seq > i_m0.seq) && (i_mcnt > CW'(1))) begin
                        num     = 2'd2;
                        mop.pop = 2'd1;
                        o_res0  = '{RK_MD, 8'd0, i_m0.idx, i_m0.seq};
                        if (i_v0.seq == i_m1.seq) begin
                            vop.pop = 2'd1;
                            mop.pop = 2'd2;
                            o_res1  = '{RK_PAIR, i_v0.idx, i_m1.idx, i_v0.seq};
                        end
                    end else if ((i_v0.seq < i_m0.seq) && (i_vcnt > CW'(1))) begin
                        num     = 2'd2;
                        vop.pop = 2'd1;
                        o_res0  = '{RK_VIDEO, i_v0.idx, 8'd0, i_v0.seq};
                        if (i_v1.seq == i_m0.seq) begin
                            vop.pop = 2'd2;
                            mop.pop = 2'd1;
                            o_res1  = '{RK_PAIR, i_v1.idx, i_m0.idx, i_m0.seq};
                        end
                    end else begin
                        num = 2'd1;
                    end
                end
            end
        endcase
    end

    assign o_vop = i_go ? vop : '0;
    assign o_mop = i_go ? mop : '0;
    assign o_num = num;

endmodule

// ----- rtl/vmsp_resbuf.sv -----
`timescale 1ns / 1ps
module vmsp_resbuf
    import vmsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_rec       i_res0,
    input  t_rec       i_res1,
    input  logic [1:0] i_num,
    output logic       o_free,
    vmsp_out_if.source o_result
);

    t_rec       r_r0;
    t_rec       r_r1;
    logic [1:0] r_num;
    logic       fire;

    assign fire   = o_result.valid && o_result.ready;
    assign o_free = (r_num == 2'd0) || ((r_num == 2'd1) && o_result.ready);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_r0 <= i_res0;
            r_r1 <= i_res1;
        end else if (fire) begin
            r_r0 <= r_r1;
        end
        if (!i_rst_n) begin
            r_num <= 2'd0;
        end else if (i_load) begin
            r_num <= i_num;
        end else if (fire) begin
            r_num <= r_num - 2'd1;
        end
    end

    assign o_result.valid         = (r_num != 2'd0);
    assign o_result.result_kind   = r_r0.result_kind;
    assign o_result.video_index   = r_r0.video_index;
    assign o_result.md_index      = r_r0.md_index;
    assign o_result.pair_sequence = r_r0.pair_sequence;
    assign o_result.last          = (r_num == 2'd1);

    a_second_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_num == 2'd2) && fire |=> (r_num == 2'd1) && !$past(i_load))
        else $error("second beat lost or overwritten");

endmodule

// ----- rtl/video_metadata_sequence_pairer.sv -----
`timescale 1ns / 1ps
// Channel    Dir  Fields
// i_item     in   kind, buffer_index, sequence_req      (valid/ready)
// o_result   out  result_kind, video_index, md_index,   (valid/ready)
//                 pair_sequence, last
// apb        in   enabled at byte address 0, bit 0
//
// An item is registered on acceptance and resolved against both queues when the result
// register is free; results leave that two-entry register one beat a cycle while ready.
// Items with zero or one result sustain one item per cycle while o_result is ready; a
// pull with two results holds the input side while the result register drains.
// Synchronous active-low reset empties both queues and clears enabled.
// Writing 0 to enabled empties both queues.
module video_metadata_sequence_pairer
    import vmsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    vmsp_in_if.sink               i_item,
    vmsp_out_if.source            o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          r_enabled;
    logic          r_in_vld;
    t_item         r_in;
    logic          cfg_wr;
    logic          cfg_clear;
    logic          free;
    logic          go;
    t_desc         v0;
    t_desc         v1;
    t_desc         m0;
    t_desc         m1;
    logic [CW-1:0] vcnt;
    logic [CW-1:0] mcnt;
    t_qop          vop;
    t_qop          mop;
    t_qop          vop_q;
    t_qop          mop_q;
    t_rec          res0;
    t_rec          res1;
    logic [1:0]    num;
    t_desc         push_desc;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_ENABLED);
    assign cfg_clear = cfg_wr && !pwdata[0];
    assign prdata    = (paddr[APB_ADDR_W-1:2] == REG_ENABLED) ?
                       {{(APB_DATA_W-1){1'b0}}, r_enabled} : '0;

    assign go           = r_in_vld && free;
    assign i_item.ready = !r_in_vld || go;

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= '{i_item.kind, i_item.buffer_index, i_item.sequence_req};
        end
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_in_vld  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_enabled <= pwdata[0];
            end
            if (i_item.valid && i_item.ready) begin
                r_in_vld <= 1'b1;
            end else if (go) begin
                r_in_vld <= 1'b0;
            end
        end
    end

    assign push_desc = '{r_in.buffer_index, r_in.sequence_req};

    always_comb begin
        vop_q       = vop;
        mop_q       = mop;
        vop_q.clear = vop.clear || cfg_clear;
        mop_q.clear = mop.clear || cfg_clear;
    end

    vmsp_decide #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_decide (
        .i_go      (go),
        .i_item    (r_in),
        .i_enabled (r_enabled),
        .i_v0      (v0),
        .i_v1      (v1),
        .i_vcnt    (vcnt),
        .i_m0      (m0),
        .i_m1      (m1),
        .i_mcnt    (mcnt),
        .o_vop     (vop),
        .o_mop     (mop),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_num     (num)
    );

    vmsp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_video_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (vop_q),
        .i_push_desc (push_desc),
        .o_front0    (v0),
        .o_front1    (v1),
        .o_count     (vcnt)
    );

    vmsp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_md_q (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (mop_q),
        .i_push_desc (push_desc),
        .o_front0    (m0),
        .o_front1    (m1),
        .o_count     (mcnt)
    );

    vmsp_resbuf u_resbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (go),
        .i_res0   (res0),
        .i_res1   (res1),
        .i_num    (num),
        .o_free   (free),
        .o_result (o_result)
    );

endmodule
